[sv/dhs_pkg.sv]
`timescale 1ns / 1ps
// dhs_pkg: shared types, codes and helpers for the disk head scheduler.
// No dependencies; used by every module of the block.
package dhs_pkg;

    // Fixed field widths
    localparam int TRACK_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Pending bitmap is stored as rows of this many tracks
    localparam int ROW_BITS = 32;
    localparam int OFF_W    = 5;

    // Parameter defaults and reset values
    localparam int TRACKS_DEF      = 1024;
    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam logic [COUNT_W-1:0] TRACK_COUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        POL_FCFS  = 2'd0,
        POL_SSTF  = 2'd1,
        POL_LOOK  = 2'd2,
        POL_CLOOK = 2'd3
    } policy_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SERVED   = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY      = 2'd0,
        CFG_TRACK_COUNT = 2'd1,
        CFG_START_HEAD  = 2'd2,
        CFG_START_DIR   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_SERVE = 1'b1
    } cmd_kind_t;

    // One queued request between front and back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [TRACK_W-1:0] track;
    } cmd_t;

    // Config writes that land in the back end's state
    typedef struct packed {
        logic               head_we;
        logic               dir_we;
        logic [TRACK_W-1:0] head;
        logic               dir;
    } cfg_wr_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RING_RD,
        S_RING_PM,
        S_RING_CHK,
        S_ADD_DEC,
        S_ADD_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NEXT,
        S_CLR_RD,
        S_CLR_WR,
        S_RESP
    } state_t;

    // Index of lowest set bit in a bitmap row
    function automatic logic [OFF_W-1:0] lowest_set(input logic [ROW_BITS-1:0] w);
        logic [OFF_W-1:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (w[i]) r = OFF_W'(i);
        end
        return r;
    endfunction

    // Index of highest set bit in a bitmap row
    function automatic logic [OFF_W-1:0] highest_set(input logic [ROW_BITS-1:0] w);
        logic [OFF_W-1:0] r;
        r = '0;
        for (int i = 0; i < ROW_BITS; i++) begin
            if (w[i]) r = OFF_W'(i);
        end
        return r;
    endfunction

endpackage

[sv/disk_head_scheduler.sv]
`timescale 1ns / 1ps
// disk_head_scheduler: top level; config registers, front queue, back end.
// Depends on dhs_pkg, dhs_front, dhs_back (and dhs_ram below it).
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata[9:0] track, s_tuser[0] req_type
//  m_        out  m_tvalid/m_tready    m_tdata[9:0] served_track, m_tuser[1:0] status
//  cfg_      in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// An add request first discards stale entries at the ring head, then is
// accepted or dropped. A serve under a positional policy scans the bitmap in
// 32-track rows (one or two scans); under FCFS it pops ring entries until it
// finds a pending track.
// After reset a clearing pass zeroes the bitmap; s_tready stays low
// meanwhile. Results wait in an output register; a two-entry request queue
// keeps the input side moving while it stalls.
module disk_head_scheduler #(
    parameter int TRACKS      = dhs_pkg::TRACKS_DEF,
    parameter int QUEUE_DEPTH = dhs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dhs_pkg::S_TDATA_W-1:0]    s_tdata,   // [9:0] track
    input  logic                             s_tuser,   // [0] req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [dhs_pkg::M_TDATA_W-1:0]    m_tdata,   // [9:0] served_track
    output logic [dhs_pkg::STATUS_W-1:0]     m_tuser,   // [1:0] status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dhs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dhs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    dhs_pkg::policy_t               policy_reg, policy_next;
    logic [dhs_pkg::COUNT_W-1:0]    track_count_reg, track_count_next;
    dhs_pkg::cfg_wr_t               cfg_wr;
    dhs_pkg::cmd_t                  cmd;
    dhs_pkg::status_t               out_status;
    logic [dhs_pkg::TRACK_W-1:0]    out_track;
    logic                           cmd_valid, cmd_pop, ready_for_cmds, cfg_acc;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // config register decode
    always_comb begin
        policy_next      = policy_reg;
        track_count_next = track_count_reg;
        cfg_wr.head_we   = 1'b0;
        cfg_wr.dir_we    = 1'b0;
        cfg_wr.head      = cfg_data[dhs_pkg::TRACK_W-1:0];
        cfg_wr.dir       = cfg_data[0];
        if (cfg_acc) begin
            unique case (dhs_pkg::cfg_index_t'(cfg_index))
                dhs_pkg::CFG_POLICY:      policy_next = dhs_pkg::policy_t'(cfg_data[1:0]);
                dhs_pkg::CFG_TRACK_COUNT: track_count_next = cfg_data;
                dhs_pkg::CFG_START_HEAD:  cfg_wr.head_we = 1'b1;
                dhs_pkg::CFG_START_DIR:   cfg_wr.dir_we = 1'b1;
                default:                  policy_next = policy_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg      <= dhs_pkg::POL_FCFS;
            track_count_reg <= dhs_pkg::TRACK_COUNT_RST;
        end else begin
            policy_reg      <= policy_next;
            track_count_reg <= track_count_next;
        end
    end

    dhs_front u_front (
        .aclk(aclk), .aresetn(aresetn), .enable(ready_for_cmds),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    dhs_back #(.TRACKS(TRACKS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .policy(policy_reg),
        .track_count(track_count_reg), .cfg_wr(cfg_wr),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
        .ready_for_cmds(ready_for_cmds),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .out_status(out_status), .out_track(out_track)
    );

    assign m_tuser = out_status;
    assign m_tdata = dhs_pkg::M_TDATA_W'(out_track);

`ifndef NO_ASSERTIONS
    // only a served result carries a track number
    a_track_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != dhs_pkg::ST_SERVED) |-> (out_track == '0))
        else $error("non-served result with nonzero track");

    // bitmap clearing pass blocks input right after reset
    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted during bitmap clearing");
`endif
endmodule

[sv/dhs_ram.sv]
`timescale 1ns / 1ps
// dhs_ram: generic single-write, single-read RAM with registered read data.
// Depends on dhs_pkg for default sizes only.
module dhs_ram #(
    parameter int WIDTH = dhs_pkg::ROW_BITS,
    parameter int DEPTH = dhs_pkg::TRACKS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

[sv/dhs_front.sv]
`timescale 1ns / 1ps
// dhs_front: accepts requests, tags them add or serve, holds them in a
// two-entry queue for the back end. Depends on dhs_pkg.
module dhs_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           enable,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dhs_pkg::S_TDATA_W-1:0]  s_tdata,   // [9:0] track
    input  logic                           s_tuser,   // [0] req_type
    output logic                           cmd_valid,
    output dhs_pkg::cmd_t                  cmd,
    input  logic                           cmd_pop
);
    dhs_pkg::cmd_t q0_reg, q0_next, q1_reg, q1_next, in_cmd;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;

    // classify incoming request
    always_comb begin
        in_cmd.kind  = s_tuser ? dhs_pkg::CMD_SERVE : dhs_pkg::CMD_ADD;
        in_cmd.track = s_tdata[dhs_pkg::TRACK_W-1:0];
    end

    assign s_tready  = enable && (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q0_reg;

    // queue update
    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (push && cmd_pop) begin
            if (cnt_reg == 2'd1) begin
                q0_next = in_cmd;
            end else begin
                q0_next = q1_reg;
                q1_next = in_cmd;
            end
        end else if (cmd_pop) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                q0_next = in_cmd;
            end else begin
                q1_next = in_cmd;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end
endmodule

[sv/dhs_back.sv]
`timescale 1ns / 1ps
// dhs_back: executes queued requests against the pending bitmap and the
// arrival ring; owns head position, sweep direction and the result register.
// Depends on dhs_pkg and dhs_ram.
module dhs_back #(
    parameter int TRACKS      = dhs_pkg::TRACKS_DEF,
    parameter int QUEUE_DEPTH = dhs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dhs_pkg::policy_t               policy,
    input  logic [dhs_pkg::COUNT_W-1:0]    track_count,
    input  dhs_pkg::cfg_wr_t               cfg_wr,
    input  logic                           cmd_valid,
    input  dhs_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    output logic                           ready_for_cmds,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output dhs_pkg::status_t               out_status,
    output logic [dhs_pkg::TRACK_W-1:0]    out_track
);
    localparam int RB   = dhs_pkg::ROW_BITS;
    localparam int OW   = dhs_pkg::OFF_W;
    localparam int TW   = dhs_pkg::TRACK_W;
    localparam int IW   = $clog2(TRACKS);
    localparam int ROWS = (TRACKS + RB - 1) / RB;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int NW   = $clog2(TRACKS + 1);
    localparam int CW   = (NW > dhs_pkg::COUNT_W) ? NW : dhs_pkg::COUNT_W;

    function automatic logic [RW-1:0] row_of(input logic [IW-1:0] idx);
        return RW'(idx >> OW);
    endfunction

    function automatic logic [OW-1:0] off_of(input logic [IW-1:0] idx);
        return OW'(idx);
    endfunction

    // state registers
    dhs_pkg::state_t  state_reg, state_next;
    logic             ph_reg, ph_next;
    logic             serve_reg, serve_next;
    logic [TW-1:0]    trk_reg, trk_next;
    logic [IW-1:0]    cand_reg, cand_next;
    logic             hit_reg, hit_next;
    logic [IW-1:0]    res_reg, res_next;
    logic             l_hit_reg, l_hit_next;
    logic [IW-1:0]    l_val_reg, l_val_next;
    logic [RW-1:0]    scan_row_reg, scan_row_next;
    logic [IW-1:0]    scan_lo_reg, scan_lo_next;
    logic [IW-1:0]    scan_hi_reg, scan_hi_next;
    logic             scan_up_reg, scan_up_next;
    logic [TW-1:0]    head_reg, head_next;
    logic             sweep_reg, sweep_next;
    logic [QW-1:0]    r_idx_reg, r_idx_next, w_idx_reg, w_idx_next;
    logic             r_ph_reg, r_ph_next, w_ph_reg, w_ph_next;
    logic [RW-1:0]    clr_row_reg, clr_row_next;
    dhs_pkg::status_t rs_status_reg, rs_status_next;
    logic [TW-1:0]    rs_track_reg, rs_track_next;
    logic             m_tvalid_reg, m_tvalid_next;
    dhs_pkg::status_t out_status_reg, out_status_next;
    logic [TW-1:0]    out_track_reg, out_track_next;

    // memory ports
    logic             pm_we, pm_re;
    logic [RW-1:0]    pm_waddr, pm_raddr;
    logic [RB-1:0]    pm_wdata, pm_rdata;
    logic             rg_we, rg_re;
    logic [QW-1:0]    rg_waddr, rg_raddr;
    logic [TW-1:0]    rg_wdata, rg_rdata;

    // derived values
    logic [CW-1:0]    n_full;
    logic [IW-1:0]    n_last;
    logic             ring_empty, ring_full;
    logic             ring_pop, ring_push;
    logic             la_req, la_up;
    logic [CW-1:0]    la_from;
    logic [RB-1:0]    ones, mask, word, bit_sel;
    logic [OW-1:0]    enc;
    logic [RW-1:0]    end_row;

    dhs_ram #(.WIDTH(RB), .DEPTH(ROWS)) u_pending (
        .aclk(aclk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .re(pm_re), .raddr(pm_raddr), .rdata(pm_rdata)
    );

    dhs_ram #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_ring (
        .aclk(aclk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
        .re(rg_re), .raddr(rg_raddr), .rdata(rg_rdata)
    );

    // tracks in use, clamped to 1..TRACKS
    always_comb begin
        if (track_count == '0) begin
            n_full = CW'(1);
        end else if (CW'(track_count) > CW'(TRACKS)) begin
            n_full = CW'(TRACKS);
        end else begin
            n_full = CW'(track_count);
        end
        n_last = IW'(n_full - CW'(1));
    end

    assign ring_empty = (r_idx_reg == w_idx_reg) && (r_ph_reg == w_ph_reg);
    assign ring_full  = (r_idx_reg == w_idx_reg) && (r_ph_reg != w_ph_reg);

    // masked bitmap row for the current scan step
    always_comb begin
        ones = '1;
        mask = ones;
        if (scan_row_reg == row_of(scan_lo_reg)) begin
            mask = mask & (ones << off_of(scan_lo_reg));
        end
        if (scan_row_reg == row_of(scan_hi_reg)) begin
            mask = mask & (ones >> (OW'(RB - 1) - off_of(scan_hi_reg)));
        end
        word    = pm_rdata & mask;
        enc     = scan_up_reg ? dhs_pkg::lowest_set(word) : dhs_pkg::highest_set(word);
        end_row = scan_up_reg ? row_of(scan_hi_reg) : row_of(scan_lo_reg);
        bit_sel = RB'(1) << off_of(cand_reg);
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        serve_next     = serve_reg;
        trk_next       = trk_reg;
        cand_next      = cand_reg;
        hit_next       = hit_reg;
        res_next       = res_reg;
        l_hit_next     = l_hit_reg;
        l_val_next     = l_val_reg;
        scan_row_next  = scan_row_reg;
        scan_lo_next   = scan_lo_reg;
        scan_hi_next   = scan_hi_reg;
        scan_up_next   = scan_up_reg;
        head_next      = head_reg;
        sweep_next     = sweep_reg;
        r_idx_next     = r_idx_reg;
        r_ph_next      = r_ph_reg;
        w_idx_next     = w_idx_reg;
        w_ph_next      = w_ph_reg;
        clr_row_next   = clr_row_reg;
        rs_status_next = rs_status_reg;
        rs_track_next  = rs_track_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_track_next = out_track_reg;
        cmd_pop        = 1'b0;
        pm_we          = 1'b0;
        pm_waddr       = row_of(IW'(trk_reg));
        pm_wdata       = '0;
        pm_re          = 1'b0;
        pm_raddr       = scan_row_reg;
        rg_we          = 1'b0;
        rg_waddr       = w_idx_reg;
        rg_wdata       = trk_reg;
        rg_re          = 1'b0;
        rg_raddr       = r_idx_reg;
        ring_pop       = 1'b0;
        ring_push      = 1'b0;
        la_req         = 1'b0;
        la_up          = 1'b0;
        la_from        = CW'(head_reg);

        unique case (state_reg)
            // zero the bitmap row by row after reset
            dhs_pkg::S_CLEAR: begin
                pm_we    = 1'b1;
                pm_waddr = clr_row_reg;
                if (clr_row_reg == RW'(ROWS - 1)) begin
                    state_next = dhs_pkg::S_IDLE;
                end else begin
                    clr_row_next = clr_row_reg + 1'b1;
                end
            end
            dhs_pkg::S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    trk_next   = cmd.track;
                    serve_next = (cmd.kind == dhs_pkg::CMD_SERVE);
                    ph_next    = 1'b0;
                    if (cmd.kind == dhs_pkg::CMD_ADD) begin
                        state_next = dhs_pkg::S_RING_RD;
                    end else begin
                        unique case (policy)
                            dhs_pkg::POL_FCFS: state_next = dhs_pkg::S_RING_RD;
                            dhs_pkg::POL_SSTF: la_req = 1'b1;
                            dhs_pkg::POL_LOOK: begin
                                la_req = 1'b1;
                                la_up  = sweep_reg;
                            end
                            dhs_pkg::POL_CLOOK: la_req = 1'b1;
                        endcase
                    end
                end
            end
            // walk the ring head: stale discard for adds, pick for FCFS
            dhs_pkg::S_RING_RD: begin
                if (ring_empty) begin
                    if (serve_reg) begin
                        rs_status_next = dhs_pkg::ST_EMPTY;
                        rs_track_next  = '0;
                        state_next     = dhs_pkg::S_RESP;
                    end else begin
                        state_next = dhs_pkg::S_ADD_DEC;
                    end
                end else begin
                    rg_re      = 1'b1;
                    state_next = dhs_pkg::S_RING_PM;
                end
            end
            dhs_pkg::S_RING_PM: begin
                cand_next  = IW'(rg_rdata);
                pm_re      = 1'b1;
                pm_raddr   = row_of(IW'(rg_rdata));
                state_next = dhs_pkg::S_RING_CHK;
            end
            dhs_pkg::S_RING_CHK: begin
                if (pm_rdata[off_of(cand_reg)]) begin
                    if (serve_reg) begin
                        ring_pop   = 1'b1;
                        state_next = dhs_pkg::S_CLR_RD;
                    end else begin
                        state_next = dhs_pkg::S_ADD_DEC;
                    end
                end else begin
                    ring_pop   = 1'b1;
                    state_next = dhs_pkg::S_RING_RD;
                end
            end
            dhs_pkg::S_ADD_DEC: begin
                if (CW'(trk_reg) >= n_full || ring_full) begin
                    rs_status_next = dhs_pkg::ST_DROPPED;
                    rs_track_next  = '0;
                    state_next     = dhs_pkg::S_RESP;
                end else begin
                    rg_we      = 1'b1;
                    ring_push  = 1'b1;
                    pm_re      = 1'b1;
                    pm_raddr   = row_of(IW'(trk_reg));
                    state_next = dhs_pkg::S_ADD_WR;
                end
            end
            dhs_pkg::S_ADD_WR: begin
                pm_we          = 1'b1;
                pm_wdata       = pm_rdata | (RB'(1) << off_of(IW'(trk_reg)));
                rs_status_next = dhs_pkg::ST_ACCEPTED;
                rs_track_next  = '0;
                state_next     = dhs_pkg::S_RESP;
            end
            dhs_pkg::S_SCAN_RD: begin
                pm_re      = 1'b1;
                state_next = dhs_pkg::S_SCAN_CHK;
            end
            dhs_pkg::S_SCAN_CHK: begin
                if (word != '0) begin
                    hit_next   = 1'b1;
                    res_next   = IW'({scan_row_reg, enc});
                    state_next = dhs_pkg::S_NEXT;
                end else if (scan_row_reg == end_row) begin
                    hit_next   = 1'b0;
                    state_next = dhs_pkg::S_NEXT;
                end else begin
                    scan_row_next = scan_up_reg ? scan_row_reg + 1'b1 : scan_row_reg - 1'b1;
                    state_next    = dhs_pkg::S_SCAN_RD;
                end
            end
            // combine scan results per policy
            dhs_pkg::S_NEXT: begin
                rs_status_next = dhs_pkg::ST_EMPTY;
                rs_track_next  = '0;
                if (!ph_reg) begin
                    ph_next = 1'b1;
                    if (policy == dhs_pkg::POL_SSTF) begin
                        l_hit_next = hit_reg;
                        l_val_next = res_reg;
                        la_req     = 1'b1;
                        la_up      = 1'b1;
                    end else if (hit_reg) begin
                        cand_next  = res_reg;
                        state_next = dhs_pkg::S_CLR_RD;
                    end else if (policy == dhs_pkg::POL_LOOK && !sweep_reg) begin
                        la_req  = 1'b1;
                        la_up   = 1'b1;
                        la_from = '0;
                    end else if (policy == dhs_pkg::POL_FCFS) begin
                        state_next = dhs_pkg::S_RESP;
                    end else begin
                        la_req  = 1'b1;
                        la_from = CW'(n_last);
                    end
                end else begin
                    state_next = dhs_pkg::S_RESP;
                    if (policy == dhs_pkg::POL_SSTF) begin
                        if (l_hit_reg && hit_reg) begin
                            if ((CW'(head_reg) - CW'(l_val_reg))
                                    <= (CW'(res_reg) - CW'(head_reg))) begin
                                cand_next = l_val_reg;
                            end else begin
                                cand_next = res_reg;
                            end
                            state_next = dhs_pkg::S_CLR_RD;
                        end else if (l_hit_reg) begin
                            cand_next  = l_val_reg;
                            state_next = dhs_pkg::S_CLR_RD;
                        end else if (hit_reg) begin
                            cand_next  = res_reg;
                            state_next = dhs_pkg::S_CLR_RD;
                        end
                    end else if (hit_reg) begin
                        if (policy == dhs_pkg::POL_LOOK) begin
                            sweep_next = !sweep_reg;
                        end
                        cand_next  = res_reg;
                        state_next = dhs_pkg::S_CLR_RD;
                    end
                end
            end
            // clear the served track and move the head
            dhs_pkg::S_CLR_RD: begin
                pm_re      = 1'b1;
                pm_raddr   = row_of(cand_reg);
                state_next = dhs_pkg::S_CLR_WR;
            end
            dhs_pkg::S_CLR_WR: begin
                pm_we          = 1'b1;
                pm_waddr       = row_of(cand_reg);
                pm_wdata       = pm_rdata & ~bit_sel;
                head_next      = TW'(cand_reg);
                rs_status_next = dhs_pkg::ST_SERVED;
                rs_track_next  = TW'(cand_reg);
                state_next     = dhs_pkg::S_RESP;
            end
            dhs_pkg::S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = rs_status_reg;
                    out_track_next  = rs_track_reg;
                    state_next      = dhs_pkg::S_IDLE;
                end
            end
            default: state_next = dhs_pkg::S_IDLE;
        endcase

        // start a bitmap search over [lo, hi]
        if (la_req) begin
            scan_up_next = la_up;
            if (la_up) begin
                if (la_from <= CW'(n_last)) begin
                    scan_lo_next  = IW'(la_from);
                    scan_hi_next  = n_last;
                    scan_row_next = row_of(IW'(la_from));
                    state_next    = dhs_pkg::S_SCAN_RD;
                end else begin
                    hit_next   = 1'b0;
                    state_next = dhs_pkg::S_NEXT;
                end
            end else begin
                scan_lo_next = '0;
                if (la_from > CW'(n_last)) begin
                    scan_hi_next  = n_last;
                    scan_row_next = row_of(n_last);
                end else begin
                    scan_hi_next  = IW'(la_from);
                    scan_row_next = row_of(IW'(la_from));
                end
                state_next = dhs_pkg::S_SCAN_RD;
            end
        end

        // ring pointer moves
        if (ring_pop) begin
            if (r_idx_reg == QW'(QUEUE_DEPTH - 1)) begin
                r_idx_next = '0;
                r_ph_next  = !r_ph_reg;
            end else begin
                r_idx_next = r_idx_reg + 1'b1;
            end
        end
        if (ring_push) begin
            if (w_idx_reg == QW'(QUEUE_DEPTH - 1)) begin
                w_idx_next = '0;
                w_ph_next  = !w_ph_reg;
            end else begin
                w_idx_next = w_idx_reg + 1'b1;
            end
        end

        // config loads head and sweep direction
        if (cfg_wr.head_we) begin
            head_next = cfg_wr.head;
        end
        if (cfg_wr.dir_we) begin
            sweep_next = cfg_wr.dir;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dhs_pkg::S_CLEAR;
            clr_row_reg  <= '0;
            head_reg     <= '0;
            sweep_reg    <= 1'b0;
            r_idx_reg    <= '0;
            r_ph_reg     <= 1'b0;
            w_idx_reg    <= '0;
            w_ph_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_row_reg  <= clr_row_next;
            head_reg     <= head_next;
            sweep_reg    <= sweep_next;
            r_idx_reg    <= r_idx_next;
            r_ph_reg     <= r_ph_next;
            w_idx_reg    <= w_idx_next;
            w_ph_reg     <= w_ph_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ph_reg         <= ph_next;
        serve_reg      <= serve_next;
        trk_reg        <= trk_next;
        cand_reg       <= cand_next;
        hit_reg        <= hit_next;
        res_reg        <= res_next;
        l_hit_reg      <= l_hit_next;
        l_val_reg      <= l_val_next;
        scan_row_reg   <= scan_row_next;
        scan_lo_reg    <= scan_lo_next;
        scan_hi_reg    <= scan_hi_next;
        scan_up_reg    <= scan_up_next;
        rs_status_reg  <= rs_status_next;
        rs_track_reg   <= rs_track_next;
        out_status_reg <= out_status_next;
        out_track_reg  <= out_track_next;
    end

    assign ready_for_cmds = (state_reg != dhs_pkg::S_CLEAR);
    assign m_tvalid       = m_tvalid_reg;
    assign out_status     = out_status_reg;
    assign out_track      = out_track_reg;
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for disk_head_scheduler.
// It predicts each result from its own scheduler model and compares every field.
// Depends on dhs_pkg and the disk_head_scheduler RTL.
module testbench;

    localparam int NTRK       = 1024;
    localparam int NQ         = 1024;
    localparam int WD_LIMIT   = 60000;
    localparam int TRACK_W    = dhs_pkg::TRACK_W;
    localparam int COUNT_W    = dhs_pkg::COUNT_W;
    localparam int S_TDATA_W  = dhs_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = dhs_pkg::M_TDATA_W;
    localparam int STATUS_W   = dhs_pkg::STATUS_W;
    localparam int CFG_IDX_W  = dhs_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = dhs_pkg::CFG_DATA_W;

    typedef struct {
        dhs_pkg::status_t   st;
        logic [TRACK_W-1:0] trk;
    } sched_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Scheduler model state
    dhs_pkg::policy_t   mdl_policy;
    logic [COUNT_W-1:0] mdl_count;
    bit                 mdl_pend [NTRK];
    logic [TRACK_W-1:0] mdl_ring [NQ];
    logic [COUNT_W-1:0] mdl_wp, mdl_rp;
    logic [TRACK_W-1:0] mdl_head;
    bit                 mdl_up;

    sched_result_t expected_results[$];
    int  mismatches = 0;
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  idle_cycles = 0;
    int  rd_mode = 0;
    int  rd_left = 0;

    disk_head_scheduler i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------- model ----------------
    function automatic int used_tracks();
        if (mdl_count == 0) return 1;
        if (mdl_count > NTRK) return NTRK;
        return int'(mdl_count);
    endfunction

    function automatic int ring_fill();
        logic [COUNT_W-1:0] d;
        d = mdl_wp - mdl_rp;
        return int'(d);
    endfunction

    function automatic int seek_down(int from);
        int i;
        i = (from < used_tracks()) ? from : used_tracks() - 1;
        for (; i >= 0; i--) if (mdl_pend[i]) return i;
        return -1;
    endfunction

    function automatic int seek_up(int from);
        for (int i = from; i < used_tracks(); i++) if (mdl_pend[i]) return i;
        return -1;
    endfunction

    function automatic int pick_next();
        int l, r, c, h;
        h = int'(mdl_head);
        c = -1;
        case (mdl_policy)
            dhs_pkg::POL_FCFS: begin
                while (ring_fill() != 0 && c < 0) begin
                    l = int'(mdl_ring[mdl_rp[9:0]]);
                    mdl_rp++;
                    if (mdl_pend[l]) c = l;
                end
            end
            dhs_pkg::POL_SSTF: begin
                l = seek_down(h);
                r = seek_up(h);
                if (l < 0) c = r;
                else if (r < 0) c = l;
                else c = (h - l <= r - h) ? l : r;
            end
            dhs_pkg::POL_LOOK: begin
                if (mdl_up) begin
                    c = seek_up(h);
                    if (c < 0) begin
                        c = seek_down(used_tracks() - 1);
                        if (c >= 0) mdl_up = 1'b0;
                    end
                end else begin
                    c = seek_down(h);
                    if (c < 0) begin
                        c = seek_up(0);
                        if (c >= 0) mdl_up = 1'b1;
                    end
                end
            end
            default: begin
                c = seek_down(h);
                if (c < 0) c = seek_down(used_tracks() - 1);
            end
        endcase
        return c;
    endfunction

    function automatic sched_result_t sched_predict(dhs_pkg::cmd_kind_t k,
                                                    logic [TRACK_W-1:0] t);
        sched_result_t res;
        int c;
        res.trk = '0;
        if (k == dhs_pkg::CMD_ADD) begin
            // drop stale entries at the ring head first
            while (ring_fill() != 0 && !mdl_pend[mdl_ring[mdl_rp[9:0]]]) mdl_rp++;
            if (int'(t) >= used_tracks() || ring_fill() >= NQ) begin
                res.st = dhs_pkg::ST_DROPPED;
            end else begin
                mdl_pend[t] = 1'b1;
                mdl_ring[mdl_wp[9:0]] = t;
                mdl_wp++;
                res.st = dhs_pkg::ST_ACCEPTED;
            end
        end else begin
            c = pick_next();
            if (c < 0) begin
                res.st = dhs_pkg::ST_EMPTY;
            end else begin
                mdl_pend[c] = 1'b0;
                mdl_head = TRACK_W'(c);
                res.trk = TRACK_W'(c);
                res.st = dhs_pkg::ST_SERVED;
            end
        end
        return res;
    endfunction

    function automatic int pending_total();
        int n;
        n = 0;
        foreach (mdl_pend[i]) n += mdl_pend[i];
        return n;
    endfunction

    // ---------------- drivers ----------------
    task automatic send_req(dhs_pkg::cmd_kind_t k, logic [TRACK_W-1:0] t);
        bit hs;
        int g;
        if (burst_left == 0) begin
            g = gaps_on ? $urandom_range(0, 10) : 0;
            if (g > 0) begin
                s_tvalid <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - TRACK_W){1'b0}}, t};
        s_tuser  <= k;
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
        expected_results.push_back(sched_predict(k, t));
        burst_left--;
    endtask

    // wait for all results, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(dhs_pkg::cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
        bit hs;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do begin
            @(negedge aclk);
            hs = cfg_ready;
            @(posedge aclk);
        end while (!hs);
        cfg_valid <= 1'b0;
        case (idx)
            dhs_pkg::CFG_POLICY:      mdl_policy = dhs_pkg::policy_t'(v[1:0]);
            dhs_pkg::CFG_TRACK_COUNT: mdl_count = v;
            dhs_pkg::CFG_START_HEAD:  mdl_head = v[TRACK_W-1:0];
            default:                  mdl_up = v[0];
        endcase
    endtask

    task automatic setup(dhs_pkg::policy_t p, logic [COUNT_W-1:0] n,
                         logic [TRACK_W-1:0] h, bit d);
        drain();
        write_reg(dhs_pkg::CFG_POLICY, COUNT_W'(p));
        write_reg(dhs_pkg::CFG_TRACK_COUNT, n);
        write_reg(dhs_pkg::CFG_START_HEAD, COUNT_W'(h));
        write_reg(dhs_pkg::CFG_START_DIR, COUNT_W'(d));
    endtask

    task automatic serve_all();
        int n;
        n = pending_total();
        repeat (n + 1) send_req(dhs_pkg::CMD_SERVE, '0);
    endtask

    // ---------------- tests ----------------
    task automatic test_reset_fcfs();
        send_req(dhs_pkg::CMD_SERVE, '0);
        send_req(dhs_pkg::CMD_ADD, 10'd1023);
        send_req(dhs_pkg::CMD_ADD, 10'd0);
        send_req(dhs_pkg::CMD_ADD, 10'd1023);
        send_req(dhs_pkg::CMD_SERVE, '0);
        send_req(dhs_pkg::CMD_SERVE, '0);
        send_req(dhs_pkg::CMD_SERVE, '0);
    endtask

    task automatic test_policies();
        // same request set under each positional policy, ties and both sweep directions
        for (int p = 1; p < 4; p++) begin
            for (int d = 0; d < 2; d++) begin
                setup(dhs_pkg::policy_t'(p), 11'd1024, 10'd500, d[0]);
                send_req(dhs_pkg::CMD_ADD, 10'd490);
                send_req(dhs_pkg::CMD_ADD, 10'd510);
                send_req(dhs_pkg::CMD_ADD, 10'd500);
                send_req(dhs_pkg::CMD_ADD, 10'd2);
                send_req(dhs_pkg::CMD_ADD, 10'd1000);
                serve_all();
            end
        end
    endtask

    task automatic test_track_count();
        // count of zero acts as one; counts above the track total saturate
        setup(dhs_pkg::POL_SSTF, 11'd0, 10'd1023, 1'b0);
        send_req(dhs_pkg::CMD_ADD, 10'd1);
        send_req(dhs_pkg::CMD_ADD, 10'd0);
        send_req(dhs_pkg::CMD_SERVE, '0);
        setup(dhs_pkg::POL_LOOK, 11'd2047, 10'd1023, 1'b1);
        send_req(dhs_pkg::CMD_ADD, 10'd1023);
        send_req(dhs_pkg::CMD_ADD, 10'd300);
        setup(dhs_pkg::POL_CLOOK, 11'd1025, 10'd0, 1'b0);
        serve_all();
        // pending tracks above a lowered count
        send_req(dhs_pkg::CMD_ADD, 10'd700);
        send_req(dhs_pkg::CMD_ADD, 10'd5);
        setup(dhs_pkg::POL_CLOOK, 11'd100, 10'd900, 1'b1);
        send_req(dhs_pkg::CMD_ADD, 10'd100);
        serve_all();
        setup(dhs_pkg::POL_FCFS, 11'd100, 10'd0, 1'b0);
        serve_all();
    endtask

    task automatic test_repeats();
        // repeated requests pile up in the arrival ring; later copies go stale
        setup(dhs_pkg::POL_FCFS, 11'd8, 10'd3, 1'b0);
        repeat (300) send_req(dhs_pkg::CMD_ADD, TRACK_W'($urandom_range(0, 9)));
        repeat (4) send_req(dhs_pkg::CMD_SERVE, '0);
        drain();
        write_reg(dhs_pkg::CFG_POLICY, COUNT_W'(dhs_pkg::POL_SSTF));
        repeat (6) send_req(dhs_pkg::CMD_SERVE, '0);
        send_req(dhs_pkg::CMD_ADD, 10'd6);
        drain();
        write_reg(dhs_pkg::CFG_POLICY, COUNT_W'(dhs_pkg::POL_FCFS));
        serve_all();
    endtask

    task automatic test_random();
        logic [COUNT_W-1:0] n;
        int u, items;
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 6))
                0: n = 11'd1;
                1: n = 11'd2;
                2: n = 11'd1024;
                3: n = 11'd2047;
                4: n = 11'd0;
                default: n = COUNT_W'($urandom_range(3, 64));
            endcase
            gaps_on = (ph % 3) != 2;
            setup(dhs_pkg::policy_t'(ph % 4), n, TRACK_W'($urandom_range(0, 1023)),
                  1'($urandom_range(0, 1)));
            u = used_tracks();
            items = $urandom_range(40, 60);
            for (int i = 0; i < items; i++) begin
                if (i == items / 2 && ph == 3) drain();
                if ($urandom_range(0, 99) < (pending_total() < 3 ? 75 : 50))
                    send_req(dhs_pkg::CMD_ADD, ($urandom_range(0, 9) < 8) ?
                             TRACK_W'($urandom_range(0, u - 1)) :
                             TRACK_W'($urandom_range(0, 1023)));
                else
                    send_req(dhs_pkg::CMD_SERVE, TRACK_W'($urandom_range(0, 1023)));
            end
        end
    endtask

    // ---------------- result checking ----------------
    always @(negedge aclk) begin
        sched_result_t e;
        if (m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d track=%0d", m_tuser, m_tdata);
            end else begin
                e = expected_results.pop_front();
                if (m_tuser !== e.st || m_tdata !== {{(M_TDATA_W - TRACK_W){1'b0}}, e.trk})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status=%0d track=%0d, got status=%0d track=%0d",
                                 e.st, e.trk, m_tuser, m_tdata);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rd_left == 0) begin
            rd_mode = $urandom_range(0, 2);
            rd_left = $urandom_range(20, 120);
        end
        rd_left--;
        case (rd_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog: cycles with no request, result or register write
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        mdl_policy = dhs_pkg::POL_FCFS;
        mdl_count  = dhs_pkg::TRACK_COUNT_RST;
        mdl_head   = '0;
        mdl_up     = 1'b0;
        mdl_wp     = '0;
        mdl_rp     = '0;
        foreach (mdl_pend[i]) mdl_pend[i] = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_fcfs();
        test_policies();
        test_track_count();
        test_repeats();
        test_random();
        drain();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
